### design/tlec_pkg.sv
`default_nettype none

package tlec_pkg;

  // result kinds
  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_DONE = 2'd1,
    KIND_BIN  = 2'd2,
    KIND_LONG = 2'd3
  } kind_t;

  // line-end modes
  localparam logic [2:0] MODE_CRLF_LF     = 3'd0;
  localparam logic [2:0] MODE_LF_CRLF     = 3'd1;
  localparam logic [2:0] MODE_LF_CRLF_PAD = 3'd2;
  localparam logic [2:0] MODE_CR_LF       = 3'd3;
  localparam logic [2:0] MODE_TO_CR       = 3'd4;
  localparam logic [2:0] MODE_PARITY      = 3'd5;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_MODE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_STRIP = 1'b1;
  localparam int CFG_DATA_W = 3;

  // character codes
  localparam logic [7:0] CH_NUL  = 8'h00;
  localparam logic [7:0] CH_BEL  = 8'h07;
  localparam logic [7:0] CH_LF   = 8'h0a;
  localparam logic [7:0] CH_CR   = 8'h0d;
  localparam logic [7:0] CH_SUB  = 8'h1a;
  localparam logic [7:0] LOW7    = 8'h7f;

  // queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  typedef struct packed {
    kind_t      kind;
    logic [7:0] val;
    logic [7:0] rep;
  } res_t;

  // one queue entry: the results of one item, one or two of them
  typedef struct packed {
    res_t r0;
    res_t r1;
    logic two;
  } plan_t;

  function automatic res_t mk_data(input logic [7:0] v);
    res_t r;
    r.kind = KIND_DATA;
    r.val  = v;
    r.rep  = 8'd1;
    return r;
  endfunction

  function automatic res_t mk_stat(input kind_t k);
    res_t r;
    r.kind = k;
    r.val  = 8'd0;
    r.rep  = 8'd1;
    return r;
  endfunction

endpackage

`default_nettype wire

### design/tlec_in_if.sv
`default_nettype none

interface tlec_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] in_byte;

  modport source (output valid, output func, output in_byte, input ready);
  modport sink   (input valid, input func, input in_byte, output ready);
endinterface

`default_nettype wire

### design/tlec_out_if.sv
`default_nettype none

interface tlec_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] out_byte;
  logic [7:0] repeat_res;
  logic       last;

  modport source (output valid, output kind, output out_byte, output repeat_res,
                  output last, input ready);
  modport sink   (input valid, input kind, input out_byte, input repeat_res,
                  input last, output ready);
endinterface

`default_nettype wire

### design/text_line_ending_converter_unit.sv
`default_nettype none
// path: the first result of an item is written into the queue when the item is accepted
//   and reaches out_ch through the output register; a stall can hold it in the queue
// throughput: one item per cycle in while the queue has room; one result per cycle
//   out while out_ch is ready, so an item with two results (inserted cr, held cr, tail before
//   status) makes the output register the bound; the queue absorbs bursts of such items
// reset: synchronous on rst_n low; clears line state, queue and output, mode 0, strip off
module text_line_ending_converter_unit
  import tlec_pkg::*;
#(
  parameter int LINE_LIMIT = 1024,
  parameter int PAD_BLOCK  = 128
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  tlec_in_if.sink                    in_ch,
  tlec_out_if.source                 out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  // configuration registers
  logic [2:0] mode_r;
  logic       strip_r;
  logic [2:0] mode_eff;

  // front to queue, queue to back
  logic  push;
  plan_t push_plan;
  logic  q_full;
  logic  head_valid;
  plan_t head;
  logic  pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_CRLF_LF;
      strip_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_MODE:  mode_r  <= cfg_wdata;
        REG_STRIP: strip_r <= cfg_wdata[0];
      endcase
    end
  end

  // the two unused mode codes behave like crlf to lf
  assign mode_eff = (mode_r > MODE_PARITY) ? MODE_CRLF_LF : mode_r;

  // front: filters and classifies each item, keeps line state,
  // and turns it into a plan of up to two results
  tlec_front #(
    .LINE_LIMIT (LINE_LIMIT),
    .PAD_BLOCK  (PAD_BLOCK)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .mode      (mode_eff),
    .strip     (strip_r),
    .q_full    (q_full),
    .push      (push),
    .push_plan (push_plan)
  );

  // short queue so the front keeps taking items while results wait
  tlec_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_plan  (push_plan),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head)
  );

  // back: plays each plan out via the output register, one result per cycle while ready
  tlec_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

`default_nettype wire

### design/tlec_front.sv
`default_nettype none

module tlec_front
  import tlec_pkg::*;
#(
  parameter int LINE_LIMIT = 1024,
  parameter int PAD_BLOCK  = 128
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  tlec_in_if.sink    in_ch,
  input  wire logic [2:0] mode,
  input  wire logic  strip,
  input  wire logic  q_full,
  output logic       push,
  output plan_t      push_plan
);

  localparam int LL_W  = $clog2(LINE_LIMIT);
  localparam int POS_W = $clog2(PAD_BLOCK);
  localparam logic [LL_W-1:0]  LL_MAX   = LL_W'(LINE_LIMIT - 2);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(PAD_BLOCK - 1);
  localparam logic [7:0]       PAD_W    = 8'(PAD_BLOCK);

  typedef enum logic [1:0] {PH_ACTIVE, PH_SUB, PH_BIN, PH_LONG} phase_t;

  phase_t            phase_r, phase_nxt;
  logic              crs_r, crs_nxt;
  logic [LL_W-1:0]   ll_r, ll_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;

  logic              accept;
  res_t              slot [2];
  logic [1:0]        cnt;
  logic [1:0]        ndata;
  logic              pos_clr;
  logic [POS_W-1:0]  pos_inc1, pos_inc2;
  res_t              pad_res;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;

  assign pos_inc1 = (pos_r == POS_LAST) ? '0 : pos_r + POS_W'(1);
  assign pos_inc2 = (pos_inc1 == POS_LAST) ? '0 : pos_inc1 + POS_W'(1);

  always_comb begin
    pad_res      = mk_data(CH_SUB);
    pad_res.rep  = PAD_W - {{(8-POS_W){1'b0}}, pos_r};
  end

  always_comb begin
    logic [7:0] b;
    logic       drop;
    kind_t      stat;
    slot[0]   = mk_stat(KIND_DONE);
    slot[1]   = mk_stat(KIND_DONE);
    cnt       = 2'd0;
    ndata     = 2'd0;
    pos_clr   = 1'b0;
    drop      = 1'b0;
    crs_nxt   = crs_r;
    ll_nxt    = ll_r;
    phase_nxt = phase_r;
    b         = in_ch.in_byte;
    unique case (phase_r)
      PH_BIN:  stat = KIND_BIN;
      PH_LONG: stat = KIND_LONG;
      default: stat = KIND_DONE;
    endcase

    if (in_ch.func) begin
      // end of file: tail output, status, back to start
      if (phase_r == PH_ACTIVE && mode != MODE_PARITY) begin
        if (mode == MODE_CRLF_LF && crs_r) begin
          slot[cnt[0]] = mk_data(CH_CR);
          cnt = cnt + 2'd1;
        end
        if (mode == MODE_LF_CRLF_PAD) begin
          slot[cnt[0]] = pad_res;
          cnt = cnt + 2'd1;
        end
      end
      slot[cnt[0]] = mk_stat(stat);
      cnt       = cnt + 2'd1;
      crs_nxt   = 1'b0;
      ll_nxt    = '0;
      pos_clr   = 1'b1;
      phase_nxt = PH_ACTIVE;
    end else if (phase_r == PH_ACTIVE) begin
      if (mode == MODE_PARITY) begin
        slot[0] = mk_data(b & LOW7);
        cnt     = 2'd1;
        ndata   = 2'd1;
      end else if (b != CH_NUL) begin
        if (b < CH_BEL || b[7]) begin
          if (strip) begin
            b    = b & LOW7;
            drop = (b < CH_BEL);
          end else begin
            phase_nxt = PH_BIN;
            slot[0]   = mk_stat(KIND_BIN);
            cnt       = 2'd1;
            drop      = 1'b1;
          end
        end
        if (!drop) begin
          if (b == CH_SUB) begin
            // logical end of text
            if (mode == MODE_CRLF_LF && crs_r) begin
              slot[0] = mk_data(CH_CR);
              cnt     = 2'd1;
            end
            if (mode == MODE_LF_CRLF_PAD) begin
              slot[0] = pad_res;
              cnt     = 2'd1;
              pos_clr = 1'b1;
            end
            crs_nxt   = 1'b0;
            phase_nxt = PH_SUB;
          end else begin
            if (b == CH_CR && mode == MODE_CR_LF) begin
              b = CH_LF;
            end
            if (b != CH_LF && ll_r >= LL_MAX) begin
              phase_nxt = PH_LONG;
              slot[0]   = mk_stat(KIND_LONG);
              cnt       = 2'd1;
            end else begin
              unique case (mode)
                MODE_CRLF_LF: begin
                  if (b == CH_LF) begin
                    slot[cnt[0]] = mk_data(CH_LF);
                    cnt = cnt + 2'd1;
                  end else begin
                    if (crs_r) begin
                      slot[cnt[0]] = mk_data(CH_CR);
                      cnt = cnt + 2'd1;
                    end
                    if (b != CH_CR) begin
                      slot[cnt[0]] = mk_data(b);
                      cnt = cnt + 2'd1;
                    end
                  end
                end
                MODE_LF_CRLF, MODE_LF_CRLF_PAD: begin
                  if (b == CH_LF && !crs_r) begin
                    slot[cnt[0]] = mk_data(CH_CR);
                    cnt = cnt + 2'd1;
                  end
                  slot[cnt[0]] = mk_data(b);
                  cnt = cnt + 2'd1;
                end
                MODE_TO_CR: begin
                  if (b == CH_LF) begin
                    if (!crs_r) begin
                      slot[cnt[0]] = mk_data(CH_CR);
                      cnt = cnt + 2'd1;
                    end
                  end else begin
                    slot[cnt[0]] = mk_data(b);
                    cnt = cnt + 2'd1;
                  end
                end
                default: begin
                  slot[cnt[0]] = mk_data(b);
                  cnt = cnt + 2'd1;
                end
              endcase
              ndata   = cnt;
              crs_nxt = (b == CH_CR);
              ll_nxt  = (b == CH_LF) ? '0 : ll_r + LL_W'(1);
            end
          end
        end
      end
    end
  end

  always_comb begin
    priority if (pos_clr) begin
      pos_nxt = '0;
    end else if (ndata == 2'd2) begin
      pos_nxt = pos_inc2;
    end else if (ndata == 2'd1) begin
      pos_nxt = pos_inc1;
    end else begin
      pos_nxt = pos_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_ACTIVE;
      crs_r   <= 1'b0;
      ll_r    <= '0;
      pos_r   <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      crs_r   <= crs_nxt;
      ll_r    <= ll_nxt;
      pos_r   <= pos_nxt;
    end
  end

  assign push         = accept && (cnt != 2'd0);
  assign push_plan.r0 = slot[0];
  assign push_plan.r1 = slot[1];
  assign push_plan.two = cnt[1];

endmodule

`default_nettype wire

### design/tlec_queue.sv
`default_nettype none

module tlec_queue
  import tlec_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire plan_t push_plan,
  input  wire logic  pop,
  output logic       full,
  output logic       head_valid,
  output plan_t      head
);

  plan_t            mem_r [Q_DEPTH];
  logic [Q_AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [Q_AW:0]    cnt_r, cnt_nxt;

  assign full       = (cnt_r == (Q_AW+1)'(Q_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + (Q_AW+1)'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - (Q_AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + Q_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + Q_AW'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_plan;
    end
  end

endmodule

`default_nettype wire

### design/tlec_back.sv
`default_nettype none

module tlec_back
  import tlec_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  head_valid,
  input  wire plan_t head,
  output logic       pop,
  tlec_out_if.source out_ch
);

  logic       valid_r;
  logic       sub_r;
  kind_t      kind_r;
  logic [7:0] val_r;
  logic [7:0] rep_r;
  logic       last_r;

  logic       load;
  logic       take;
  logic       cur_last;
  res_t       cur;

  assign load     = !valid_r || out_ch.ready;
  assign take     = load && head_valid;
  assign cur      = sub_r ? head.r1 : head.r0;
  assign cur_last = sub_r || !head.two;
  assign pop      = take && cur_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sub_r   <= 1'b0;
    end else if (load) begin
      valid_r <= head_valid;
      if (take) begin
        sub_r <= !cur_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      kind_r <= cur.kind;
      val_r  <= cur.val;
      rep_r  <= cur.rep;
      last_r <= cur_last;
    end
  end

  assign out_ch.valid      = valid_r;
  assign out_ch.kind       = kind_r;
  assign out_ch.out_byte   = val_r;
  assign out_ch.repeat_res = rep_r;
  assign out_ch.last       = last_r;

endmodule

`default_nettype wire

### design/tlec_checker.sv
`default_nettype none

module tlec_checker
  import tlec_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] out_kind,
  input wire logic [7:0] out_byte,
  input wire logic [7:0] out_repeat,
  input wire logic       out_last
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable({out_kind, out_byte, out_repeat, out_last}))
    else $error("stalled result changed");

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk) $rose(rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  // a status closes its item and carries no byte
  a_status_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_DATA |->
      out_last && out_byte == 8'd0 && out_repeat == 8'd1)
    else $error("malformed status result");

  // only padding repeats, and padding is sub
  a_pad_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_repeat != 8'd1 |->
      out_kind == KIND_DATA && out_byte == CH_SUB && out_repeat != 8'd0)
    else $error("bad repeated result");

endmodule

bind text_line_ending_converter_unit tlec_checker u_tlec_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_kind   (out_ch.kind),
  .out_byte   (out_ch.out_byte),
  .out_repeat (out_ch.repeat_res),
  .out_last   (out_ch.last)
);

`default_nettype wire

### bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import tlec_pkg::*;

  localparam int LINE_MAX  = 1024;
  localparam int PAD_SIZE  = 128;
  // cycles to let pass after the last expected result, so that items
  // with no result are surely through the pipe
  localparam int DRAIN_GAP = 6;
  localparam int PRINT_CAP = 100;

  // input item function codes
  localparam logic FN_DATA = 1'b0;
  localparam logic FN_EOF  = 1'b1;

  // predicted stream state
  typedef enum logic [1:0] {
    SS_ACTIVE = 2'd0,
    SS_SUB    = 2'd1,
    SS_BIN    = 2'd2,
    SS_LONG   = 2'd3
  } stream_state_t;

  // one expected output result
  typedef struct {
    kind_t      kind;
    logic [7:0] chr;
    logic [7:0] copies;
    logic       last;
  } conv_res_t;

  logic clk;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  tlec_in_if  in_ch ();
  tlec_out_if out_ch ();

  text_line_ending_converter_unit #(
    .LINE_LIMIT(LINE_MAX),
    .PAD_BLOCK (PAD_SIZE)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // idling percentages for sender and receiver
  int tx_idle_pct;
  int rx_idle_pct;
  int fail_count;
  int items_sent;

  // predictor copy of the registers and the line state
  logic [2:0]    cfg_mode;
  logic          cfg_strip;
  logic          cr_seen;
  logic [9:0]    line_len;
  logic [6:0]    out_pos;
  stream_state_t stream_st;

  // results of the item being predicted, then the queue of results still due
  conv_res_t item_results[$];
  conv_res_t pending_results[$];

  // receiver: random back-pressure, changed on the falling edge
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  task automatic report_mismatch(input string what);
    if (fail_count < PRINT_CAP) $display("mismatch at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  // ---------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------

  // modes 6 and 7 behave as crlf to lf
  function automatic logic [2:0] live_mode();
    return (cfg_mode > MODE_PARITY) ? MODE_CRLF_LF : cfg_mode;
  endfunction

  task automatic emit(input kind_t k, input logic [7:0] c, input logic [7:0] n);
    conv_res_t r;
    r.kind   = k;
    r.chr    = c;
    r.copies = n;
    r.last   = 1'b0;
    item_results.push_back(r);
    // a full block of 128 wraps the position back onto itself
    if (k == KIND_DATA) out_pos = out_pos + n[6:0];
  endtask

  // end of text: release a held cr in mode 0, then pad to the block boundary in mode 2
  task automatic flush_tail(input logic [2:0] m);
    if (m == MODE_CRLF_LF && cr_seen) emit(KIND_DATA, CH_CR, 8'd1);
    cr_seen = 1'b0;
    if (m == MODE_LF_CRLF_PAD) emit(KIND_DATA, CH_SUB, 8'(PAD_SIZE - int'(out_pos)));
  endtask

  task automatic clear_line_state();
    cr_seen   = 1'b0;
    line_len  = '0;
    out_pos   = '0;
    stream_st = SS_ACTIVE;
  endtask

  // one data byte while the stream is active, in a line-ending mode
  task automatic convert_text_byte(input logic [7:0] b, input logic [2:0] m);
    logic [7:0] c;
    c = b;
    if (c == CH_NUL) return;
    // control bytes below bel and high-bit bytes: strip or reject
    if (c < CH_BEL || c[7]) begin
      if (!cfg_strip) begin
        stream_st = SS_BIN;
        emit(KIND_BIN, 8'd0, 8'd1);
        return;
      end
      c = c & LOW7;
      if (c < CH_BEL) return;
    end
    if (c == CH_SUB) begin
      flush_tail(m);
      stream_st = SS_SUB;
      return;
    end
    if (c == CH_CR && m == MODE_CR_LF) c = CH_LF;
    // lf may always close a line, anything else at the limit is an error
    if (c != CH_LF && int'(line_len) + 1 >= LINE_MAX - 1) begin
      stream_st = SS_LONG;
      emit(KIND_LONG, 8'd0, 8'd1);
      return;
    end
    line_len++;
    case (m)
      MODE_CRLF_LF: begin
        // a held cr before lf is dropped, before anything else released
        if (c == CH_LF) begin
          emit(KIND_DATA, CH_LF, 8'd1);
        end else begin
          if (cr_seen) emit(KIND_DATA, CH_CR, 8'd1);
          if (c != CH_CR) emit(KIND_DATA, c, 8'd1);
        end
      end
      MODE_LF_CRLF, MODE_LF_CRLF_PAD: begin
        if (c == CH_LF && !cr_seen) emit(KIND_DATA, CH_CR, 8'd1);
        emit(KIND_DATA, c, 8'd1);
      end
      MODE_TO_CR: begin
        // lf turns into cr unless a cr came just before it
        if (c == CH_LF) begin
          if (!cr_seen) emit(KIND_DATA, CH_CR, 8'd1);
        end else begin
          emit(KIND_DATA, c, 8'd1);
        end
      end
      default: begin
        emit(KIND_DATA, c, 8'd1);
      end
    endcase
    cr_seen = (c == CH_CR);
    if (c == CH_LF) line_len = '0;
  endtask

  // works out the results of one accepted item and queues them
  task automatic convert_item(input logic f, input logic [7:0] b);
    logic [2:0] m;
    kind_t      status;
    m = live_mode();
    item_results.delete();
    if (f == FN_EOF) begin
      if (stream_st == SS_ACTIVE && m != MODE_PARITY) flush_tail(m);
      case (stream_st)
        SS_BIN:  status = KIND_BIN;
        SS_LONG: status = KIND_LONG;
        default: status = KIND_DONE;
      endcase
      emit(status, 8'd0, 8'd1);
      clear_line_state();
    end else if (stream_st == SS_ACTIVE) begin
      // parity mode passes everything with bit 7 cleared
      if (m == MODE_PARITY) emit(KIND_DATA, b & LOW7, 8'd1);
      else convert_text_byte(b, m);
    end
    if (item_results.size() != 0) item_results[item_results.size() - 1].last = 1'b1;
    foreach (item_results[i]) pending_results.push_back(item_results[i]);
  endtask

  // ---------------------------------------------------------------------
  // result checker, sampled on the rising edge
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    conv_res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result with none due: kind %0d byte %02h x%0d last %0b",
                                  out_ch.kind, out_ch.out_byte, out_ch.repeat_res,
                                  out_ch.last));
      end else begin
        want = pending_results.pop_front();
        if (out_ch.kind !== want.kind || out_ch.out_byte !== want.chr ||
            out_ch.repeat_res !== want.copies || out_ch.last !== want.last) begin
          report_mismatch($sformatf({"got kind %0d byte %02h x%0d last %0b, ",
                                     "want kind %0d byte %02h x%0d last %0b"},
                                    out_ch.kind, out_ch.out_byte, out_ch.repeat_res,
                                    out_ch.last, want.kind, want.chr, want.copies,
                                    want.last));
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // stimulus helpers; each is entered and left on a falling edge
  // ---------------------------------------------------------------------

  // sends one item, with random idle cycles ahead of it
  task automatic send_item(input logic f, input logic [7:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.func    <= f;
    in_ch.in_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    convert_item(f, b);
    items_sent++;
    @(negedge clk);
  endtask

  // holds the input until every due result has come, then waits a little more
  task automatic drain(input int extra);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
    @(negedge clk);
  endtask

  // writes both registers; only called while the block is idle
  task automatic set_config(input logic [2:0] m, input logic s);
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_MODE;
    cfg_wdata <= m;
    @(negedge clk);
    cfg_idx   <= REG_STRIP;
    cfg_wdata <= CFG_DATA_W'(s);
    @(negedge clk);
    cfg_we    <= 1'b0;
    cfg_mode  = m;
    cfg_strip = s;
  endtask

  // mostly plain text with line ends, now and then a nul, sub or binary byte
  function automatic logic [7:0] random_text_byte();
    int pick;
    pick = $urandom_range(99);
    if (pick < 50) return 8'($urandom_range(8'h20, 8'h7e));
    if (pick < 65) return CH_CR;
    if (pick < 80) return CH_LF;
    if (pick < 83) return CH_NUL;
    if (pick < 86) return CH_SUB;
    if (pick < 90) return 8'($urandom_range(1, 6));
    if (pick < 95) return 8'($urandom_range(8'h80, 8'hff));
    return 8'($urandom_range(255));
  endfunction

  // ---------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------

  // crlf to lf: held cr dropped before lf, released before text and at sub,
  // data after sub gives nothing
  task automatic test_crlf_to_lf();
    set_config(MODE_CRLF_LF, 1'b0);
    send_item(FN_DATA, "a");
    send_item(FN_DATA, CH_CR);
    send_item(FN_DATA, CH_LF);
    send_item(FN_DATA, CH_CR);
    send_item(FN_DATA, "b");
    send_item(FN_DATA, CH_CR);
    send_item(FN_DATA, CH_SUB);
    send_item(FN_DATA, "x");
    send_item(FN_EOF, 8'h00);
    drain(DRAIN_GAP);
  endtask

  // padding mode with strip on: high bit cleared, stripped low byte dropped,
  // then a partial pad and a full block on an empty stream
  task automatic test_padding();
    set_config(MODE_LF_CRLF_PAD, 1'b1);
    send_item(FN_DATA, 8'hff);
    send_item(FN_DATA, 8'h81);
    send_item(FN_DATA, 8'h8a);
    send_item(FN_EOF, 8'hff);
    send_item(FN_EOF, 8'h00);
    drain(DRAIN_GAP);
  endtask

  // unused mode value, nul dropped, high-bit byte raises the binary error
  // and silences the rest of the stream
  task automatic test_binary_error();
    set_config(3'd7, 1'b0);
    send_item(FN_DATA, "q");
    send_item(FN_DATA, CH_NUL);
    send_item(FN_DATA, 8'h80);
    send_item(FN_DATA, "z");
    send_item(FN_EOF, 8'h00);
    drain(DRAIN_GAP);
  endtask

  // parity strip: no filtering, sub and control bytes pass through
  task automatic test_parity_strip();
    set_config(MODE_PARITY, 1'b0);
    send_item(FN_DATA, 8'hff);
    send_item(FN_DATA, CH_SUB);
    send_item(FN_DATA, 8'h01);
    send_item(FN_EOF, 8'h00);
    drain(DRAIN_GAP);
  endtask

  // to-cr mode (lf after cr gives nothing) and cr to lf mode
  task automatic test_cr_modes();
    set_config(MODE_TO_CR, 1'b0);
    send_item(FN_DATA, CH_CR);
    send_item(FN_DATA, CH_LF);
    send_item(FN_DATA, CH_LF);
    send_item(FN_EOF, 8'h00);
    drain(DRAIN_GAP);
    set_config(MODE_CR_LF, 1'b0);
    send_item(FN_DATA, CH_CR);
    send_item(FN_DATA, "k");
    send_item(FN_EOF, 8'h00);
    drain(DRAIN_GAP);
  endtask

  // random streams under random settings, mostly closed by end of file
  task automatic run_random_streams(input int item_goal);
    int         first;
    int         len;
    logic [2:0] m;
    logic       s;
    first = items_sent;
    while (items_sent - first < item_goal) begin
      m = 3'($urandom_range(7));
      s = 1'($urandom_range(1));
      set_config(m, s);
      len = $urandom_range(1, 14);
      repeat (len) begin
        // now and then hold off until the output has caught up
        if ($urandom_range(19) == 0) drain(0);
        send_item(FN_DATA, random_text_byte());
      end
      if ($urandom_range(9) != 0) send_item(FN_EOF, 8'($urandom_range(255)));
      drain(DRAIN_GAP);
    end
  endtask

  // ---------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------
  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = REG_MODE;
    cfg_wdata     = '0;
    in_ch.valid   = 1'b0;
    in_ch.func    = FN_DATA;
    in_ch.in_byte = 8'h00;
    out_ch.ready  = 1'b0;
    fail_count    = 0;
    items_sent    = 0;
    cfg_mode      = MODE_CRLF_LF;
    cfg_strip     = 1'b0;
    clear_line_state();
    // sender idles less than the receiver at first
    tx_idle_pct   = 31;
    rx_idle_pct   = 56;

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    test_crlf_to_lf();
    test_padding();
    test_binary_error();
    test_parity_strip();
    test_cr_modes();
    run_random_streams(25);

    // swap the idling
    tx_idle_pct = 56;
    rx_idle_pct = 31;
    run_random_streams(25);

    // full rate both ways
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_random_streams(25);

    drain(DRAIN_GAP);
    if (fail_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #5_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule

### sim.f
design/tlec_pkg.sv
design/tlec_in_if.sv
design/tlec_out_if.sv
design/tlec_front.sv
design/tlec_queue.sv
design/tlec_back.sv
design/text_line_ending_converter_unit.sv
design/tlec_checker.sv
bench/tb_top.sv
